[rtl/gspm_pkg.sv]
package gspm_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W       = 4;   // vertex index field width
   localparam int VCNT_W       = 5;   // vertex_count register width
   localparam int LEN_W        = 4;   // path_length field width
   localparam int REQ_TDATA_W  = 16;  // 10 payload bits, padded to bytes
   localparam int RSP_TDATA_W  = 8;   // 7 payload bits, padded to bytes

   localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);
   localparam logic [VCNT_W-1:0] VCNT_MAX   = VCNT_W'(MAX_VERTICES);

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VIDX_W-1:0]       vidx_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   // edge edit into the adjacency store
   typedef struct packed {
      logic     en;
      logic     set;
      vidx_type a;
      vidx_type b;
   } adj_edit_type;

   // frontier unit command
   typedef struct packed {
      logic     load;    // frontier <= row
      logic     accum;   // acc |= row when tap is in frontier
      logic     commit;  // frontier <= acc including this row
      vidx_type tap;
      vidx_type dst;
   } fu_cmd_type;

   // bits below n set
   function automatic row_type vertex_mask(input logic [VCNT_W-1:0] n);
      row_type m;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         m[i] = (VCNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

[rtl/gspm_adj_store.sv]
module gspm_adj_store
   import gspm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  adj_edit_type edit,
   input  vidx_type     rd_addr,
   output row_type      rd_row
);

   row_type rows_ff [MAX_VERTICES];

   // both symmetric bits in the same cycle; a self loop hits the same bit twice
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (edit.en) begin
         rows_ff[edit.a][edit.b] <= edit.set;
         rows_ff[edit.b][edit.a] <= edit.set;
      end
   end

   assign rd_row = rows_ff[rd_addr];

endmodule

[rtl/gspm_frontier_unit.sv]
module gspm_frontier_unit
   import gspm_pkg::*;
(
   input  logic       clock,
   input  fu_cmd_type cmd,
   input  row_type    row,
   input  row_type    mask,
   output logic       hit
);

   row_type frontier_ff;
   row_type acc_ff;
   row_type masked;
   row_type acc_in;

   assign masked = row & mask;
   assign acc_in = frontier_ff[cmd.tap] ? (acc_ff | masked) : acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         frontier_ff <= masked;
         acc_ff      <= '0;
      end else if (cmd.commit) begin
         frontier_ff <= acc_in;
         acc_ff      <= '0;
      end else if (cmd.accum) begin
         acc_ff <= acc_in;
      end
   end

   assign hit = frontier_ff[cmd.dst];

endmodule

[rtl/graph_shortest_path_matrix.sv]
// Undirected graph held as a 16 x 16 adjacency bit matrix, with a
// shortest-path search over it.
//
// req_*: one item per accepted beat: operation (insert edge, remove edge,
//   query edge, shortest path) and two vertex indices.
// rsp_*: exactly one result item per request: edge_present, path_length,
//   path_found and indices_valid.
// csr_*: vertex_count write; change it only while the block is idle.
//
// One item is in work at a time; req_tready is high only when the sequencer
// is idle. Edit and query items go through EXEC and then DONE, which loads the
// result. A path search scans the frontier one adjacency row per cycle through
// a shared OR accumulator: each level is a CHECK of the destination followed
// by a scan of the n live rows (n = effective vertex count).
// The result sits in an output register; the next item is taken while it
// waits. A finished result that cannot be loaded because rsp is stalled
// holds the sequencer until rsp_tready frees the register.
// Reset (synchronous) clears all edges, sets vertex_count to 16 and empties
// the output register.
module graph_shortest_path_matrix
   import gspm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] operation, [5:2] src_vertex, [9:6] dst_vertex, [15:10] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] edge_present, [4:1] path_length, [5] path_found, [6] indices_valid, [7] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [VCNT_W-1:0]      csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [VCNT_W-1:0]         count_ff;
   op_type                    op_ff;
   vidx_type                  src_ff;
   vidx_type                  dst_ff;
   logic                      valid_ff;
   logic [LEN_W-1:0]          k_ff;
   vidx_type                  v_ff;
   logic                      res_present_ff;
   logic [LEN_W-1:0]          res_len_ff;
   logic                      res_found_ff;
   logic                      rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff;

   logic [VCNT_W-1:0]         n_eff;
   logic [VCNT_W-1:0]         n_last;
   row_type                   mask;
   logic                      req_acc;
   logic                      valid_in;
   logic                      out_free;
   vidx_type                  rd_addr;
   row_type                   rd_row;
   adj_edit_type              edit;
   fu_cmd_type                fu_cmd;
   logic                      hit;

   // counts above the matrix size clamp to it
   assign n_eff  = (count_ff > VCNT_MAX) ? VCNT_MAX : count_ff;
   assign n_last = n_eff - VCNT_W'(1);
   assign mask   = vertex_mask(n_eff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign valid_in   = ({1'b0, req_tdata[5:2]} < n_eff) && ({1'b0, req_tdata[9:6]} < n_eff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // one row read per cycle: source row while executing, frontier tap while scanning
   assign rd_addr = (state_ff == ST_SCAN) ? v_ff : src_ff;

   always_comb begin
      edit     = '0;
      edit.set = (op_ff == OP_INSERT);
      edit.a   = src_ff;
      edit.b   = dst_ff;
      if (state_ff == ST_EXEC && valid_ff &&
          (op_ff == OP_INSERT || op_ff == OP_REMOVE)) begin
         edit.en = 1'b1;
      end
   end

   always_comb begin
      fu_cmd     = '0;
      fu_cmd.tap = v_ff;
      fu_cmd.dst = dst_ff;
      case (state_ff)
         ST_EXEC: begin
            fu_cmd.load = (op_ff == OP_SEARCH);
         end
         ST_SCAN: begin
            fu_cmd.commit = ({1'b0, v_ff} == n_last);
            fu_cmd.accum  = ({1'b0, v_ff} != n_last);
         end
         default: begin
         end
      endcase
   end

   gspm_adj_store u_adj (
      .clock   (clock),
      .reset   (reset),
      .edit    (edit),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   gspm_frontier_unit u_fu (
      .clock (clock),
      .cmd   (fu_cmd),
      .row   (rd_row),
      .mask  (mask),
      .hit   (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= VCNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  op_ff    <= op_type'(req_tdata[1:0]);
                  src_ff   <= req_tdata[5:2];
                  dst_ff   <= req_tdata[9:6];
                  valid_ff <= valid_in;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               res_present_ff <= (op_ff == OP_QUERY) && valid_ff && rd_row[dst_ff];
               res_len_ff     <= '0;
               // same vertex: trivial path of length 0
               res_found_ff   <= (op_ff == OP_SEARCH) && valid_ff && (src_ff == dst_ff);
               if (op_ff == OP_SEARCH && valid_ff && src_ff != dst_ff) begin
                  k_ff     <= LEN_W'(1);
                  state_ff <= ST_CHECK;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_CHECK: begin
               if (hit) begin
                  res_found_ff <= 1'b1;
                  res_len_ff   <= k_ff;
                  state_ff     <= ST_DONE;
               end else if ({1'b0, k_ff} == n_last) begin
                  state_ff <= ST_DONE;   // destination not reached at the last level
               end else begin
                  v_ff     <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if ({1'b0, v_ff} == n_last) begin
                  k_ff     <= k_ff + LEN_W'(1);
                  state_ff <= ST_CHECK;
               end else begin
                  v_ff <= v_ff + VIDX_W'(1);
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, valid_ff, res_found_ff, res_len_ff, res_present_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/gspm_checker.sv]
module gspm_checker
   import gspm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   // an accepted item keeps the sequencer busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after accept");

   // found or present needs valid indices
   a_found_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5] || rsp_tdata[0]) |-> rsp_tdata[6])
      else $error("result flag set with invalid indices");

   // no path means zero length
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[5] |-> rsp_tdata[4:1] == '0)
      else $error("nonzero length without a path");

endmodule

bind graph_shortest_path_matrix gspm_checker u_gspm_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import gspm_pkg::*;

   // Runaway guard. The slowest correct run is every item a full-size search
   // plus random stalls, well inside this limit.
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int TOTAL_ITEMS  = 1650;   // directed items plus random traffic
   localparam int MAX_REPORTS  = 50;     // keep the log short on a broken build

   // Result item as it sits in rsp_tdata[6:0]; the first member is the top bit.
   typedef struct packed {
      logic             indices_valid;
      logic             path_found;
      logic [LEN_W-1:0] path_length;
      logic             edge_present;
   } graph_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [1:0] operation, [5:2] src_vertex, [9:6] dst_vertex, [15:10] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] edge_present, [4:1] path_length, [5] path_found, [6] indices_valid, [7] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [VCNT_W-1:0]      csr_wr_data = '0;

   // Shadow copy of the block's state: adjacency rows and the vertex count.
   row_type           graph_rows [MAX_VERTICES];
   logic [VCNT_W-1:0] vcount_shadow;

   graph_result_type pending_results [$];   // oldest expected result first
   int               chain_order [MAX_VERTICES];
   int               items_sent    = 0;
   int               error_count   = 0;
   int               cycle_count   = 0;
   int               req_gap_pct   = 20;
   int               rsp_stall_pct = 20;

   graph_shortest_path_matrix DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side back-pressure, changed on the falling edge like every input.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Counts above the matrix size behave as the full matrix.
   function automatic int live_vertices();
      return (vcount_shadow > VCNT_MAX) ? MAX_VERTICES : int'(vcount_shadow);
   endfunction

   // Applies one item to the shadow graph and returns the result it must give.
   // The search walks exact-length frontiers: each frontier holds every vertex that a
   // walk from the source of that level's length reaches, within the live vertices.
   function automatic graph_result_type predict_graph_op(op_type op, vidx_type s,
                                                        vidx_type d);
      graph_result_type r;
      int               n;
      row_type          live_mask;
      row_type          frontier;
      row_type          next_frontier;
      r = '0;
      n = live_vertices();
      r.indices_valid = (int'(s) < n) && (int'(d) < n);
      if (r.indices_valid) begin
         case (op)
            OP_INSERT: begin
               graph_rows[s][d] = 1'b1;
               graph_rows[d][s] = 1'b1;
            end
            OP_REMOVE: begin
               graph_rows[s][d] = 1'b0;
               graph_rows[d][s] = 1'b0;
            end
            OP_QUERY: begin
               r.edge_present = graph_rows[s][d];
            end
            default: begin
               if (s == d) begin
                  r.path_found = 1'b1;      // trivial path, length 0
               end else begin
                  live_mask = '0;
                  for (int i = 0; i < n; i++) live_mask[i] = 1'b1;
                  frontier = graph_rows[s] & live_mask;
                  for (int k = 1; k < n && !r.path_found; k++) begin
                     if (frontier[d]) begin
                        r.path_found  = 1'b1;
                        r.path_length = LEN_W'(k);
                     end else begin
                        next_frontier = '0;
                        for (int v = 0; v < n; v++) begin
                           if (frontier[v]) next_frontier |= graph_rows[v] & live_mask;
                        end
                        frontier = next_frontier;
                     end
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < MAX_REPORTS) begin
         $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
      end
      error_count++;
   endtask

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      graph_result_type got;
      graph_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = graph_result_type'(rsp_tdata[6:0]);
         if (pending_results.size() == 0) begin
            report_mismatch("result item with none pending, tdata", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.edge_present != want.edge_present)
               report_mismatch("edge_present", got.edge_present, want.edge_present);
            if (got.path_length != want.path_length)
               report_mismatch("path_length", got.path_length, want.path_length);
            if (got.path_found != want.path_found)
               report_mismatch("path_found", got.path_found, want.path_found);
            if (got.indices_valid != want.indices_valid)
               report_mismatch("indices_valid", got.indices_valid, want.indices_valid);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offers one item, with random gaps ahead of it, and returns on the edge
   // that accepts it. tvalid stays high until the next falling edge, so
   // back-to-back items keep it high without a glitch.
   task automatic send_item(op_type op, vidx_type s, vidx_type d);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({d, s, op});
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_graph_op(op, s, d));
      items_sent++;
   endtask

   // Every item gives one result, so the block is idle once all have arrived;
   // the extra wait afterwards covers the output register.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_vertex_count(logic [VCNT_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      vcount_shadow = value;
   endtask

   // Removes every stored edge; the caller sets the full vertex count first.
   task automatic clear_graph();
      for (int s = 0; s < MAX_VERTICES; s++) begin
         for (int d = s; d < MAX_VERTICES; d++) begin
            if (graph_rows[s][d]) send_item(OP_REMOVE, vidx_type'(s), vidx_type'(d));
         end
      end
   endtask

   // Random ordering of the first n vertices into chain_order.
   task automatic shuffle_vertices(int n);
      int j;
      int held;
      for (int i = 0; i < n; i++) chain_order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         held = chain_order[i];
         chain_order[i] = chain_order[j];
         chain_order[j] = held;
      end
   endtask

   // Path along chain_order, len edges long.
   task automatic insert_chain(int len);
      for (int i = 0; i < len; i++) begin
         send_item(OP_INSERT, vidx_type'(chain_order[i]), vidx_type'(chain_order[i + 1]));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Edits and queries on the reset graph: corner indices, self loop,
   // double remove, trivial and missing paths.
   task automatic test_edge_edits();
      send_item(OP_QUERY,  4'd0,  4'd15);   // empty after reset
      send_item(OP_SEARCH, 4'd3,  4'd3);    // same vertex: found, length 0
      send_item(OP_SEARCH, 4'd0,  4'd15);   // no path
      send_item(OP_INSERT, 4'd0,  4'd15);
      send_item(OP_QUERY,  4'd15, 4'd0);    // symmetric bit set
      send_item(OP_INSERT, 4'd7,  4'd7);    // self loop, single diagonal bit
      send_item(OP_QUERY,  4'd7,  4'd7);
      send_item(OP_SEARCH, 4'd7,  4'd7);
      send_item(OP_SEARCH, 4'd15, 4'd0);
      send_item(OP_REMOVE, 4'd15, 4'd0);
      send_item(OP_QUERY,  4'd0,  4'd15);
      send_item(OP_REMOVE, 4'd0,  4'd15);   // already gone
      send_item(OP_INSERT, 4'd1,  4'd2);
      send_item(OP_INSERT, 4'd2,  4'd3);
      send_item(OP_SEARCH, 4'd1,  4'd3);    // two hops
      send_item(OP_SEARCH, 4'd15, 4'd15);
   endtask

   // Count extremes, invalid indices, and edges hidden by a reduced count.
   task automatic test_vertex_count();
      send_item(OP_INSERT, 4'd0, 4'd5);
      send_item(OP_INSERT, 4'd5, 4'd2);
      set_vertex_count(5'd4);
      send_item(OP_SEARCH, 4'd0, 4'd2);     // route via vertex 5 is hidden
      send_item(OP_QUERY,  4'd0, 4'd5);     // index out of range
      send_item(OP_INSERT, 4'd6, 4'd1);     // ignored
      send_item(OP_SEARCH, 4'd3, 4'd1);
      set_vertex_count(5'd0);               // nothing is valid
      send_item(OP_QUERY,  4'd0, 4'd0);
      send_item(OP_SEARCH, 4'd0, 4'd0);
      set_vertex_count(5'd1);
      send_item(OP_INSERT, 4'd0, 4'd0);
      send_item(OP_SEARCH, 4'd0, 4'd0);
      set_vertex_count(5'd31);              // clamps to the full matrix
      send_item(OP_SEARCH, 4'd0, 4'd2);     // hidden route back in view
      send_item(OP_QUERY,  4'd1, 4'd6);
   endtask

   // A Hamiltonian chain over all 16 vertices gives the longest answer (15);
   // cutting it gives a full-length search that finds nothing.
   task automatic test_long_path();
      set_vertex_count(5'd16);
      clear_graph();
      shuffle_vertices(MAX_VERTICES);
      insert_chain(MAX_VERTICES - 1);
      send_item(OP_SEARCH, vidx_type'(chain_order[0]), vidx_type'(chain_order[15]));
      send_item(OP_SEARCH, vidx_type'(chain_order[15]), vidx_type'(chain_order[0]));
      repeat (4) begin
         send_item(OP_SEARCH, vidx_type'($urandom_range(15)),
                   vidx_type'($urandom_range(15)));
      end
      send_item(OP_REMOVE, vidx_type'(chain_order[7]), vidx_type'(chain_order[8]));
      send_item(OP_SEARCH, vidx_type'(chain_order[0]), vidx_type'(chain_order[15]));
   endtask

   // Vertex count for one random phase: mostly mid sizes, some full, a few
   // out-of-range or degenerate values.
   function automatic logic [VCNT_W-1:0] pick_vertex_count();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         case ($urandom_range(3))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd17;
            default: return 5'd31;
         endcase
      end
      if (r < 3) return 5'd16;
      return VCNT_W'($urandom_range(2, 15));
   endfunction

   // Mostly well-formed items on live vertices, searches weighted up; a tenth
   // (all when n is 0) are fully random noise that may leave the live range.
   task automatic random_item(int n);
      op_type   op;
      vidx_type s;
      vidx_type d;
      int       r;
      r = $urandom_range(99);
      if (r < 10 || n == 0) begin
         op = op_type'($urandom_range(3));
         s  = vidx_type'($urandom_range(15));
         d  = vidx_type'($urandom_range(15));
      end else begin
         if (r < 25)      op = OP_INSERT;
         else if (r < 40) op = OP_REMOVE;
         else if (r < 55) op = OP_QUERY;
         else             op = OP_SEARCH;
         s = vidx_type'($urandom_range(n - 1));
         d = vidx_type'($urandom_range(n - 1));
      end
      send_item(op, s, d);
   endtask

   // Phases of random traffic. Each phase picks a count, seeds a random chain
   // so long paths exist, then mixes edits, queries and searches. Every third
   // phase starts from an empty graph so it does not saturate. One phase runs
   // without any idling on either side.
   task automatic test_random_traffic();
      int  phase_num;
      int  n;
      bit  quiet;
      phase_num = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (phase_num % 3 == 0) begin
            set_vertex_count(5'd16);
            clear_graph();
         end
         set_vertex_count(pick_vertex_count());
         quiet = (phase_num == 2);
         req_gap_pct   = quiet ? 0 : 20;
         rsp_stall_pct = quiet ? 0 : 20;
         n = live_vertices();
         if (n >= 2) begin
            shuffle_vertices(n);
            insert_chain($urandom_range(1, n - 1));
         end
         repeat (quiet ? 250 : 90) random_item(n);
         phase_num++;
      end
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      for (int i = 0; i < MAX_VERTICES; i++) graph_rows[i] = '0;
      vcount_shadow = VCNT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_edits();
      test_vertex_count();
      test_long_path();
      test_random_traffic();

      drain_results();
      repeat (16) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
